// ===== src/wpd_pkg.sv =====
// Shared types, constants and register codes of the windowed peak detector.
`timescale 1ns / 1ps

package wpd_pkg;

  // Fixed field widths
  localparam int SAMPLE_BITS    = 12;
  localparam int PEAK_INDEX_W   = 10;
  localparam int PEAK_NUMBER_W  = 11;
  localparam int MIN_DIST_W     = 8;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 12;

  // Parameter defaults
  localparam int FRAME_MAX_DEFAULT     = 1024;
  localparam int WINDOW_RADIUS_DEFAULT = 5;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PEAK_LIMIT   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_DISTANCE = 2'd2;

  // Register reset values
  localparam logic [SAMPLE_BITS-1:0]   THRESHOLD_RESET    = 12'd1000;
  localparam logic [PEAK_NUMBER_W-1:0] PEAK_LIMIT_RESET   = 11'd100;
  localparam logic [MIN_DIST_W-1:0]    MIN_DISTANCE_RESET = 8'd10;

  // Input beat
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;
  } samp_beat_t;

  // Result beat
  typedef struct packed {
    logic                     has_peak;
    logic [PEAK_INDEX_W-1:0]  peak_index;
    logic [SAMPLE_BITS-1:0]   peak_amplitude;
    logic [PEAK_NUMBER_W-1:0] peak_number;
    logic                     frame_too_long;
    logic                     end_of_frame;
  } rec_beat_t;

  // Configuration registers
  typedef struct packed {
    logic [SAMPLE_BITS-1:0]   threshold;
    logic [PEAK_NUMBER_W-1:0] peak_limit;
    logic [MIN_DIST_W-1:0]    min_distance;
  } cfg_t;

  // Control part of a queue entry: a qualified candidate or a frame-end marker
  typedef struct packed {
    logic                   is_end;
    logic                   tail;
    logic                   frame_long;
    logic [SAMPLE_BITS-1:0] amp;
  } item_ctl_t;

endpackage

// ===== src/wpd_front.sv =====
// Front end: sample window, local-maximum test and frame-end tail sequencing.
`timescale 1ns / 1ps

module wpd_front #(
  parameter int FRAME_MAX     = wpd_pkg::FRAME_MAX_DEFAULT,
  parameter int WINDOW_RADIUS = wpd_pkg::WINDOW_RADIUS_DEFAULT,
  parameter int IDX_W         = $clog2(FRAME_MAX)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             samp_valid,
  output logic                             samp_stall,
  input  wpd_pkg::samp_beat_t              samp_data,
  input  logic [wpd_pkg::SAMPLE_BITS-1:0]  threshold,
  output logic                             q_push,
  output wpd_pkg::item_ctl_t               q_ctl,
  output logic [IDX_W-1:0]                 q_idx,
  input  logic                             q_full
);

  localparam int WIN_LEN = 2 * WINDOW_RADIUS + 1;
  localparam int CNT_W   = $clog2(FRAME_MAX + 1);
  localparam int PAD_W   = $clog2(WINDOW_RADIUS + 1);
  localparam int SUM_W   = $clog2(FRAME_MAX + WINDOW_RADIUS + 1);

  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_PAD = 2'd1;
  localparam logic [1:0] ST_END = 2'd2;

  logic [1:0]       state;
  logic [CNT_W-1:0] cnt;
  logic [PAD_W-1:0] pad;
  logic             frame_long;

  // Taps by age: entry 0 is the newest sample
  logic [wpd_pkg::SAMPLE_BITS-1:0] sample_window [WIN_LEN];

  logic [wpd_pkg::SAMPLE_BITS-1:0] view [WIN_LEN];
  logic [wpd_pkg::SAMPLE_BITS-1:0] center;
  logic [WIN_LEN-1:0]              live;
  logic [CNT_W-1:0]                cnt_v;
  logic [PAD_W-1:0]                pad_v;
  logic [SUM_W-1:0]                sum_v;
  logic                            samp_accept;
  logic                            at_max;
  logic                            decide_en;
  logic                            cand_ok;
  logic                            qualified;
  logic                            end_push;

  assign samp_stall  = (state != ST_RUN) || q_full;
  assign samp_accept = samp_valid && !samp_stall;
  assign at_max      = (cnt == CNT_W'(FRAME_MAX));

  // Counts as seen after this step; a pad step shifts in a dead entry
  assign cnt_v = (state == ST_RUN) ? CNT_W'(cnt + CNT_W'(1)) : cnt;
  assign pad_v = (state == ST_RUN) ? '0 : PAD_W'(pad + PAD_W'(1));
  assign sum_v = SUM_W'(cnt_v) + SUM_W'(pad_v);

  always_comb begin
    case (state)
      ST_RUN:  decide_en = samp_accept && !at_max;
      ST_PAD:  decide_en = !q_full;
      default: decide_en = 1'b0;
    endcase
  end

  // Window as it stands after the shift
  always_comb begin
    view[0] = (state == ST_RUN) ? samp_data.sample : '0;
    for (int b = 1; b < WIN_LEN; b++) begin
      view[b] = sample_window[b-1];
    end
  end

  // A tap is live when its position lies inside the frame's real samples
  always_comb begin
    for (int b = 0; b < WIN_LEN; b++) begin
      live[b] = (SUM_W'(b) >= SUM_W'(pad_v)) && (SUM_W'(b) < sum_v);
    end
  end

  // Local-maximum test around the center tap
  assign center = view[WINDOW_RADIUS];
  always_comb begin
    qualified = (center > threshold);
    for (int b = 0; b < WIN_LEN; b++) begin
      if (b != WINDOW_RADIUS && live[b] && view[b] > center) begin
        qualified = 1'b0;
      end
    end
  end

  // Center position must be at least one
  assign cand_ok  = (sum_v >= SUM_W'(WINDOW_RADIUS + 2));
  assign end_push = (state == ST_END) && !q_full;

  assign q_push           = (decide_en && cand_ok && qualified) || end_push;
  assign q_ctl.is_end     = (state == ST_END);
  assign q_ctl.tail       = (state == ST_PAD) || samp_data.last;
  assign q_ctl.frame_long = frame_long;
  assign q_ctl.amp        = center;
  assign q_idx            = IDX_W'(sum_v - SUM_W'(WINDOW_RADIUS + 1));

  // Sequencer: run, tail pads after the last beat, then the frame-end marker
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_RUN;
      cnt        <= '0;
      pad        <= '0;
      frame_long <= 1'b0;
    end else begin
      case (state)
        ST_RUN: begin
          if (samp_accept) begin
            if (at_max) begin
              frame_long <= 1'b1;
            end else begin
              cnt <= cnt_v;
            end
            if (samp_data.last) begin
              pad   <= '0;
              state <= (WINDOW_RADIUS > 1) ? ST_PAD : ST_END;
            end
          end
        end
        ST_PAD: begin
          if (!q_full) begin
            pad <= pad_v;
            if (pad_v == PAD_W'(WINDOW_RADIUS - 1)) begin
              state <= ST_END;
            end
          end
        end
        ST_END: begin
          if (!q_full) begin
            cnt        <= '0;
            frame_long <= 1'b0;
            state      <= ST_RUN;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  // Window shift line
  always_ff @(posedge clk) begin
    if (decide_en) begin
      for (int b = 0; b < WIN_LEN; b++) begin
        sample_window[b] <= view[b];
      end
    end
  end

endmodule

// ===== src/wpd_queue.sv =====
// Short queue between the front end and the peak tracker.
`timescale 1ns / 1ps

module wpd_queue #(
  parameter int IDX_W = $clog2(wpd_pkg::FRAME_MAX_DEFAULT)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  wpd_pkg::item_ctl_t  push_ctl,
  input  logic [IDX_W-1:0]    push_idx,
  output logic                full,
  input  logic                pop,
  output wpd_pkg::item_ctl_t  pop_ctl,
  output logic [IDX_W-1:0]    pop_idx,
  output logic                empty
);

  localparam int QD    = wpd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(QD);
  localparam int CNT_W = $clog2(QD + 1);

  wpd_pkg::item_ctl_t ctl_mem [QD];
  logic [IDX_W-1:0]   idx_mem [QD];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full    = (count == CNT_W'(QD));
  assign empty   = (count == '0);
  assign pop_ctl = ctl_mem[rd_ptr];
  assign pop_idx = idx_mem[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QD - 1)) ? '0 : PTR_W'(wr_ptr + PTR_W'(1));
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QD - 1)) ? '0 : PTR_W'(rd_ptr + PTR_W'(1));
      end
      if (push && !pop) begin
        count <= CNT_W'(count + CNT_W'(1));
      end else if (pop && !push) begin
        count <= CNT_W'(count - CNT_W'(1));
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ctl_mem[wr_ptr] <= push_ctl;
      idx_mem[wr_ptr] <= push_idx;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
`endif

endmodule

// ===== src/wpd_back.sv =====
// Back end: held-peak tracking, merging, peak budget and result register.
`timescale 1ns / 1ps

module wpd_back #(
  parameter int IDX_W = $clog2(wpd_pkg::FRAME_MAX_DEFAULT)
) (
  input  logic                clk,
  input  logic                rst,
  input  wpd_pkg::cfg_t       cfg,
  input  wpd_pkg::item_ctl_t  q_ctl,
  input  logic [IDX_W-1:0]    q_idx,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                rec_valid,
  input  logic                rec_stall,
  output wpd_pkg::rec_beat_t  rec_data
);

  localparam int NUM_W = wpd_pkg::PEAK_NUMBER_W;
  localparam int CMP_W = (IDX_W > wpd_pkg::MIN_DIST_W) ? IDX_W : wpd_pkg::MIN_DIST_W;

  logic [IDX_W-1:0]                held_index, held_index_next;
  logic [wpd_pkg::SAMPLE_BITS-1:0] held_amplitude, held_amplitude_next;
  logic                            held_valid, held_valid_next;
  logic [NUM_W-1:0]                peaks_reported, peaks_reported_next;
  logic                            detection_stopped, detection_stopped_next;
  logic                            tail_used, tail_used_next;
  logic                            rec_valid_next;
  wpd_pkg::rec_beat_t              rec_data_next;

  logic             out_free;
  logic             emit;
  logic             near;
  logic [IDX_W-1:0] idx_gap;
  logic [NUM_W:0]   total;
  logic [NUM_W-1:0] next_number;

  assign out_free    = !rec_valid || !rec_stall;
  assign q_pop       = !q_empty && out_free;
  assign idx_gap     = IDX_W'(q_idx - held_index);
  assign near        = held_valid && (CMP_W'(idx_gap) < CMP_W'(cfg.min_distance));
  assign total       = {1'b0, peaks_reported} + (NUM_W + 1)'(held_valid);
  assign next_number = NUM_W'(peaks_reported + NUM_W'(1));

  // Decision on the queue head
  always_comb begin
    held_index_next        = held_index;
    held_amplitude_next    = held_amplitude;
    held_valid_next        = held_valid;
    peaks_reported_next    = peaks_reported;
    detection_stopped_next = detection_stopped;
    tail_used_next         = tail_used;
    emit                   = 1'b0;
    rec_data_next          = rec_data;

    if (q_pop) begin
      if (q_ctl.is_end) begin
        // Frame end: flush the held peak or give an empty record
        emit                         = 1'b1;
        rec_data_next.has_peak       = held_valid;
        rec_data_next.peak_index     = held_valid ? wpd_pkg::PEAK_INDEX_W'(held_index) : '0;
        rec_data_next.peak_amplitude = held_valid ? held_amplitude : '0;
        rec_data_next.peak_number    = held_valid ? next_number : '0;
        rec_data_next.frame_too_long = q_ctl.frame_long;
        rec_data_next.end_of_frame   = 1'b1;
        held_index_next              = '0;
        held_amplitude_next          = '0;
        held_valid_next              = 1'b0;
        peaks_reported_next          = '0;
        detection_stopped_next       = 1'b0;
        tail_used_next               = 1'b0;
      end else if (!detection_stopped) begin
        if (near) begin
          // Close candidate merges, keeping the strictly larger one
          if (q_ctl.amp > held_amplitude) begin
            held_index_next     = q_idx;
            held_amplitude_next = q_ctl.amp;
          end
        end else if (total >= {1'b0, cfg.peak_limit}) begin
          detection_stopped_next = 1'b1;
        end else if (!(held_valid && q_ctl.tail && tail_used)) begin
          // Far candidate: report the held peak and hold the new one
          if (held_valid) begin
            emit                         = 1'b1;
            rec_data_next.has_peak       = 1'b1;
            rec_data_next.peak_index     = wpd_pkg::PEAK_INDEX_W'(held_index);
            rec_data_next.peak_amplitude = held_amplitude;
            rec_data_next.peak_number    = next_number;
            rec_data_next.frame_too_long = 1'b0;
            rec_data_next.end_of_frame   = 1'b0;
            peaks_reported_next          = next_number;
            tail_used_next               = tail_used || q_ctl.tail;
          end
          held_index_next     = q_idx;
          held_amplitude_next = q_ctl.amp;
          held_valid_next     = 1'b1;
        end
      end
    end

    if (emit) begin
      rec_valid_next = 1'b1;
    end else if (out_free) begin
      rec_valid_next = 1'b0;
    end else begin
      rec_valid_next = rec_valid;
    end
  end

  // Tracker state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      held_index        <= '0;
      held_amplitude    <= '0;
      held_valid        <= 1'b0;
      peaks_reported    <= '0;
      detection_stopped <= 1'b0;
      tail_used         <= 1'b0;
      rec_valid         <= 1'b0;
    end else begin
      held_index        <= held_index_next;
      held_amplitude    <= held_amplitude_next;
      held_valid        <= held_valid_next;
      peaks_reported    <= peaks_reported_next;
      detection_stopped <= detection_stopped_next;
      tail_used         <= tail_used_next;
      rec_valid         <= rec_valid_next;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    rec_data <= rec_data_next;
  end

`ifndef SYNTHESIS
  a_mid_frame_has_peak: assert property (@(posedge clk) disable iff (rst)
    (rec_valid && !rec_data.end_of_frame) |-> (rec_data.has_peak && !rec_data.frame_too_long))
    else $error("mid-frame record without a peak");
  a_empty_record_zero: assert property (@(posedge clk) disable iff (rst)
    (rec_valid && !rec_data.has_peak) |->
      (rec_data.peak_index == '0 && rec_data.peak_amplitude == '0 &&
       rec_data.peak_number == '0))
    else $error("empty record carries peak fields");
`endif

endmodule

// ===== src/windowed_peak_detector_top.sv =====
// Top level of the windowed peak detector: registers and block wiring.
`timescale 1ns / 1ps

// Windowed local-maximum peak detector. One 12-bit sample beat is taken per
// clock inside a frame unless samp_stall holds it; a position is reported
// once WINDOW_RADIUS later samples have arrived, through a four-entry queue
// and an output register, so the result path may stall without stopping
// sample intake until the queue fills. After the beat that carries last,
// samp_stall stays high while the front end steps the WINDOW_RADIUS-1 tail
// positions of the frame through the window compare, one per step, and then
// queues the frame-end record; a full queue stretches any of these steps.
// Samples beyond FRAME_MAX are consumed and ignored, and the frame-end
// record flags them. Each non-final record reports one peak; every frame
// ends with exactly one record that has end_of_frame set. Registers are
// written through the cfg channel, which is always ready; the user must
// write them only while the block is idle; the block does not enforce it.

module windowed_peak_detector_top #(
  parameter int FRAME_MAX     = wpd_pkg::FRAME_MAX_DEFAULT,
  parameter int WINDOW_RADIUS = wpd_pkg::WINDOW_RADIUS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              samp_valid,
  output logic                              samp_stall,
  input  wpd_pkg::samp_beat_t               samp_data,
  output logic                              rec_valid,
  input  logic                              rec_stall,
  output wpd_pkg::rec_beat_t                rec_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wpd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [wpd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IDX_W = $clog2(FRAME_MAX);

  wpd_pkg::cfg_t      cfg;
  wpd_pkg::item_ctl_t push_ctl;
  wpd_pkg::item_ctl_t pop_ctl;
  logic [IDX_W-1:0]   push_idx;
  logic [IDX_W-1:0]   pop_idx;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold    <= wpd_pkg::THRESHOLD_RESET;
      cfg.peak_limit   <= wpd_pkg::PEAK_LIMIT_RESET;
      cfg.min_distance <= wpd_pkg::MIN_DISTANCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wpd_pkg::REG_THRESHOLD: begin
          cfg.threshold <= cfg_data[wpd_pkg::SAMPLE_BITS-1:0];
        end
        wpd_pkg::REG_PEAK_LIMIT: begin
          cfg.peak_limit <= cfg_data[wpd_pkg::PEAK_NUMBER_W-1:0];
        end
        wpd_pkg::REG_MIN_DISTANCE: begin
          cfg.min_distance <= cfg_data[wpd_pkg::MIN_DIST_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  wpd_front #(
    .FRAME_MAX     (FRAME_MAX),
    .WINDOW_RADIUS (WINDOW_RADIUS),
    .IDX_W         (IDX_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .samp_valid (samp_valid),
    .samp_stall (samp_stall),
    .samp_data  (samp_data),
    .threshold  (cfg.threshold),
    .q_push     (q_push),
    .q_ctl      (push_ctl),
    .q_idx      (push_idx),
    .q_full     (q_full)
  );

  wpd_queue #(
    .IDX_W (IDX_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_ctl (push_ctl),
    .push_idx (push_idx),
    .full     (q_full),
    .pop      (q_pop),
    .pop_ctl  (pop_ctl),
    .pop_idx  (pop_idx),
    .empty    (q_empty)
  );

  wpd_back #(
    .IDX_W (IDX_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_ctl     (pop_ctl),
    .q_idx     (pop_idx),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall),
    .rec_data  (rec_data)
  );

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the windowed peak detector: stream driver, predictor and checker.
`timescale 1ns / 1ps

module tb;

  localparam int FRM_MAX      = wpd_pkg::FRAME_MAX_DEFAULT;
  localparam int RAD          = wpd_pkg::WINDOW_RADIUS_DEFAULT;
  localparam int WLEN         = 2 * RAD + 1;
  localparam int LIMIT_CYCLES = 600000;
  localparam int SETTLE       = RAD + 15;
  localparam int SB           = wpd_pkg::SAMPLE_BITS;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            samp_valid = 1'b0;
  logic                            samp_stall;
  wpd_pkg::samp_beat_t             samp_data  = '0;
  logic                            rec_valid;
  logic                            rec_stall  = 1'b0;
  wpd_pkg::rec_beat_t              rec_data;
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  logic [wpd_pkg::CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [wpd_pkg::CFG_DATA_W-1:0]  cfg_data   = '0;

  windowed_peak_detector_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .samp_valid(samp_valid),
    .samp_stall(samp_stall),
    .samp_data (samp_data),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall),
    .rec_data  (rec_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Pending sample beats and expected peak records
  wpd_pkg::samp_beat_t samp_q[$];
  wpd_pkg::rec_beat_t  expected_recs[$];
  int         items_queued = 0;
  int         errs         = 0;
  int         recs_seen    = 0;
  int         cycles       = 0;
  logic       samp_fire    = 1'b0;

  // Register copies seen by the predictor
  int unsigned thr_cur   = wpd_pkg::THRESHOLD_RESET;
  int unsigned limit_cur = wpd_pkg::PEAK_LIMIT_RESET;
  int unsigned mind_cur  = wpd_pkg::MIN_DISTANCE_RESET;

  // Predictor state for the current frame
  logic [SB-1:0] win_buf [0:WLEN-1];
  int unsigned frame_pos  = 0;
  int unsigned hold_idx   = 0;
  int unsigned hold_amp   = 0;
  bit          hold_ok    = 1'b0;
  int unsigned peaks_out  = 0;
  bit          detect_off = 1'b0;
  bit          frame_over = 1'b0;
  int          tail_slot  = 0;

  // Fixed frame with ties, a threshold-level sample and a peak on the second-to-last slot
  logic [SB-1:0] shape_frame [0:18] = '{
    12'd0, 12'd1001, 12'd1000, 12'd1001, 12'd4095, 12'd4095, 12'd0, 12'd2048,
    12'd0, 12'd3000, 12'd2999, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
    12'd3500, 12'd12
  };

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned win_at(int unsigned newest, int unsigned pos);
    int unsigned back;
    back = newest - pos;
    if (back >= WLEN) return 0;
    return win_buf[WLEN - 1 - back];
  endfunction

  function automatic void push_rec(bit has, int unsigned idx, int unsigned amp,
                                   int unsigned num, bit tl, bit eof);
    wpd_pkg::rec_beat_t r;
    r.has_peak       = has;
    r.peak_index     = idx[wpd_pkg::PEAK_INDEX_W-1:0];
    r.peak_amplitude = amp[SB-1:0];
    r.peak_number    = num[wpd_pkg::PEAK_NUMBER_W-1:0];
    r.frame_too_long = tl;
    r.end_of_frame   = eof;
    expected_recs.push_back(r);
  endfunction

  // Decide whether position c is a peak; may emit the held one
  function automatic void judge_candidate(int unsigned c, int unsigned newest,
                                          int unsigned fend);
    int unsigned s, lo, hi, tot, j;
    if (detect_off) return;
    s = win_at(newest, c);
    if (s <= thr_cur) return;
    lo = (c > RAD) ? c - RAD : 0;
    hi = (c + RAD < fend) ? c + RAD : fend;
    for (j = lo; j <= hi; j++) begin
      if (j != c && win_at(newest, j) > s) return;
    end
    // close to the held peak: merge, larger one wins
    if (hold_ok && (c - hold_idx) < mind_cur) begin
      if (s > hold_amp) begin
        hold_idx = c;
        hold_amp = s;
      end
      return;
    end
    tot = peaks_out + (hold_ok ? 1 : 0);
    if (tot >= limit_cur) begin
      detect_off = 1'b1;
      return;
    end
    if (hold_ok) begin
      // only one far candidate per step may push out the held peak
      if (tail_slot <= 0) return;
      tail_slot--;
      push_rec(1'b1, hold_idx, hold_amp, peaks_out + 1, 1'b0, 1'b0);
      peaks_out++;
    end
    hold_idx = c;
    hold_amp = s;
    hold_ok  = 1'b1;
  endfunction

  function automatic void peak_predict_step(logic [SB-1:0] s, logic lst);
    int unsigned n, fend, first, c;
    int k;
    tail_slot = 1;
    if (frame_pos >= FRM_MAX) begin
      // overlong frame: beat is dropped, frame judged as ending at FRM_MAX-1
      frame_over = 1'b1;
      fend  = FRM_MAX - 1;
      first = (fend > RAD - 1) ? fend - RAD + 1 : 0;
    end else begin
      n = frame_pos;
      for (k = 0; k < WLEN - 1; k++) win_buf[k] = win_buf[k + 1];
      win_buf[WLEN - 1] = s;
      frame_pos++;
      fend = n;
      if (!lst) begin
        if (n >= RAD + 1) judge_candidate(n - RAD, n, FRM_MAX);
        return;
      end
      first = (n > RAD) ? n - RAD : 0;
    end
    if (!lst) return;
    // frame end: decide tail positions, then the closing record
    if (first < 1) first = 1;
    for (c = first; c + 1 <= fend; c++) judge_candidate(c, fend, fend);
    if (hold_ok)
      push_rec(1'b1, hold_idx, hold_amp, peaks_out + 1, frame_over, 1'b1);
    else
      push_rec(1'b0, 0, 0, 0, frame_over, 1'b1);
    frame_pos  = 0;
    hold_idx   = 0;
    hold_amp   = 0;
    hold_ok    = 1'b0;
    peaks_out  = 0;
    detect_off = 1'b0;
    frame_over = 1'b0;
  endfunction

  // ---------------------------------------------------------------- monitor

  // Predict on accepted samples, check accepted records
  always @(posedge clk) begin
    wpd_pkg::rec_beat_t want;
    cycles++;
    if (rst) begin
      samp_fire <= 1'b0;
    end else begin
      samp_fire <= samp_valid && !samp_stall;
      if (samp_valid && !samp_stall) peak_predict_step(samp_data.sample, samp_data.last);
      if (rec_valid && !rec_stall) begin
        recs_seen++;
        if (expected_recs.size() == 0) begin
          $error("record beat with nothing expected: %p", rec_data);
          errs++;
        end else begin
          want = expected_recs.pop_front();
          if (rec_data.has_peak !== want.has_peak) begin
            $error("has_peak: expected %0d, got %0d", want.has_peak, rec_data.has_peak);
            errs++;
          end
          if (rec_data.peak_index !== want.peak_index) begin
            $error("peak_index: expected %0d, got %0d", want.peak_index,
                   rec_data.peak_index);
            errs++;
          end
          if (rec_data.peak_amplitude !== want.peak_amplitude) begin
            $error("peak_amplitude: expected %0d, got %0d", want.peak_amplitude,
                   rec_data.peak_amplitude);
            errs++;
          end
          if (rec_data.peak_number !== want.peak_number) begin
            $error("peak_number: expected %0d, got %0d", want.peak_number,
                   rec_data.peak_number);
            errs++;
          end
          if (rec_data.frame_too_long !== want.frame_too_long) begin
            $error("frame_too_long: expected %0d, got %0d", want.frame_too_long,
                   rec_data.frame_too_long);
            errs++;
          end
          if (rec_data.end_of_frame !== want.end_of_frame) begin
            $error("end_of_frame: expected %0d, got %0d", want.end_of_frame,
                   rec_data.end_of_frame);
            errs++;
          end
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    if (cycles >= LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------- driver

  // Sample beats go out in bursts with random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (rst) begin
      samp_valid <= 1'b0;
    end else if (!samp_valid || samp_fire) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        samp_valid <= 1'b0;
      end else if (samp_q.size() > 0) begin
        samp_data  <= samp_q.pop_front();
        samp_valid <= 1'b1;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        samp_valid <= 1'b0;
      end
    end
  end

  // Record side back-pressure: changing modes plus long hold-offs
  int  hold_left     = 0;
  int  mode_left     = 0;
  int  stall_mode    = 0;
  bit  big_hold_done = 1'b0;

  always @(negedge clk) begin
    logic s;
    if (rst) begin
      rec_stall <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        s = 1'b1;
      end else if (recs_seen >= 20 && samp_q.size() > 100 && !big_hold_done) begin
        // one long hold while samples keep coming, to back up the block
        big_hold_done = 1'b1;
        hold_left     = 300;
        s = 1'b1;
      end else if ($urandom_range(0, 4999) == 0) begin
        hold_left = $urandom_range(80, 250);
        s = 1'b1;
      end else begin
        if (mode_left <= 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(20, 120);
        end
        mode_left = mode_left - 1;
        case (stall_mode)
          0: s = 1'b0;
          1: s = ($urandom_range(0, 3) == 0);
          2: s = ($urandom_range(0, 3) != 0);
          default: s = !rec_stall;
        endcase
      end
      rec_stall <= s;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_beat(logic [SB-1:0] s, logic lst);
    wpd_pkg::samp_beat_t b;
    b.sample = s;
    b.last   = lst;
    samp_q.push_back(b);
    items_queued++;
  endtask

  // style 0 uniform, 1 spikes over a low floor, 2 coarse levels with ties,
  // 3 hovering around the threshold
  task automatic add_frame(int len, int style);
    int i, v;
    for (i = 0; i < len; i++) begin
      case (style)
        0: v = $urandom_range(0, 4095);
        1: v = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 900);
        2: v = $urandom_range(0, 3) * 1365;
        default: begin
          v = thr_cur + $urandom_range(0, 4);
          v = v - 2;
          if (v < 0) v = 0;
          if (v > 4095) v = 4095;
        end
      endcase
      push_beat(v[SB-1:0], i == len - 1);
    end
  endtask

  task automatic add_random_frames(int n_items);
    int target, len;
    target = items_queued + n_items;
    while (items_queued < target) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(31, 120) : $urandom_range(1, 30);
      add_frame(len, $urandom_range(0, 3));
    end
  endtask

  task automatic cfg_write(logic [wpd_pkg::CFG_INDEX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[wpd_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      wpd_pkg::REG_THRESHOLD:    thr_cur   = val[SB-1:0];
      wpd_pkg::REG_PEAK_LIMIT:   limit_cur = val[wpd_pkg::PEAK_NUMBER_W-1:0];
      wpd_pkg::REG_MIN_DISTANCE: mind_cur  = val[wpd_pkg::MIN_DIST_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(int unsigned thr, int unsigned mp, int unsigned md);
    cfg_write(wpd_pkg::REG_THRESHOLD, thr);
    cfg_write(wpd_pkg::REG_PEAK_LIMIT, mp);
    cfg_write(wpd_pkg::REG_MIN_DISTANCE, md);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sender holds until every beat is out and every record is back
  task automatic wait_drained();
    while (samp_q.size() != 0 || samp_valid || expected_recs.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int i;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: single and two-sample frames, a three-sample frame with a
    // center peak, full-scale values, ties and a peak on the second-to-last slot
    push_beat(12'd4095, 1'b1);
    push_beat(12'd0, 1'b0);
    push_beat(12'd4095, 1'b1);
    push_beat(12'd0, 1'b0);
    push_beat(12'd4095, 1'b0);
    push_beat(12'd0, 1'b1);
    for (i = 0; i < 19; i++) push_beat(shape_frame[i], i == 18);

    // Reset register values
    add_random_frames(35);
    wait_drained();

    set_regs(0, 1024, 1);
    add_random_frames(25);
    wait_drained();

    set_regs(4095, 1, 255);
    add_random_frames(15);
    wait_drained();

    // no peaks at all
    set_regs(500, 0, 10);
    add_random_frames(15);
    wait_drained();

    // merge distance under the window radius: crowded tails
    set_regs(2000, 3, 2);
    add_random_frames(25);
    wait_drained();

    // every candidate counts as far
    set_regs(1000, 1024, 0);
    add_random_frames(25);
    wait_drained();

    set_regs(3000, 2, 4);
    add_random_frames(20);
    wait_drained();

    repeat (3) begin
      set_regs($urandom_range(200, 3500), $urandom_range(0, 12), $urandom_range(1, 12));
      add_random_frames(10);
      wait_drained();
    end

    // An overlong frame, then a short frame after it
    set_regs(1500, 1024, 3);
    add_frame(FRM_MAX + 2, 1);
    add_frame(4, 0);
    wait_drained();

    repeat (50) @(posedge clk);
    if (errs == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
